[sv/swdc_pkg.sv]
// ----------------------------------------------------------------------------
// swdc_pkg
// Shared constants and types for the sliding-window distinct counter: value
// and window sizes, derived widths, register map and the request/response
// structs between the top level and the histogram unit.
// ----------------------------------------------------------------------------
package swdc_pkg;

  localparam int VALUE_COUNT = 128;
  localparam int WINDOW_MAX  = 128;

  localparam int SAMPLE_W = $clog2(VALUE_COUNT);
  localparam int PTR_W    = $clog2(WINDOW_MAX);
  localparam int FILL_W   = $clog2(WINDOW_MAX + 1);
  localparam int COUNT_W  = 8;
  localparam int WSIZE_W  = 8;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_WINDOW_SIZE = 1'b0;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_IDX_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One item on its way into the histogram unit
  typedef struct packed {
    logic                vld;
    logic                start;
    logic                evict;
    logic                emit;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] old;
  } hist_req_t;

  // Result leaving the histogram unit
  typedef struct packed {
    logic               vld;
    logic [COUNT_W-1:0] distinct;
  } hist_rsp_t;

endpackage

[sv/swdc_in_if.sv]
// ----------------------------------------------------------------------------
// swdc_in_if
// Sample channel: valid/ready handshake carrying a sample and a start flag.
// ----------------------------------------------------------------------------
interface swdc_in_if;
  import swdc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                start_req;

  modport source (output valid, output sample, output start_req, input ready);
  modport sink   (input valid, input sample, input start_req, output ready);

endinterface

[sv/swdc_out_if.sv]
// ----------------------------------------------------------------------------
// swdc_out_if
// Result channel: valid/ready handshake carrying the distinct count.
// ----------------------------------------------------------------------------
interface swdc_out_if;
  import swdc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] distinct;

  modport source (output valid, output distinct, input ready);
  modport sink   (input valid, input distinct, output ready);

endinterface

[sv/swdc_hist.sv]
// ----------------------------------------------------------------------------
// swdc_hist
// Histogram unit. Each value's count is kept as the difference of an
// increment memory and a decrement memory, so every item needs at most one write per
// memory. Reads are issued from the stage before the update, writes forwarded to the next item.
// ----------------------------------------------------------------------------
module swdc_hist (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  swdc_pkg::hist_req_t req,
  output swdc_pkg::hist_rsp_t rsp
);
  import swdc_pkg::*;

  logic [COUNT_W-1:0] inc_mem [VALUE_COUNT];
  logic [COUNT_W-1:0] dec_mem [VALUE_COUNT];
  logic [VALUE_COUNT-1:0] inc_valid;
  logic [VALUE_COUNT-1:0] dec_valid;

  logic [COUNT_W-1:0] inc_rd_v, inc_rd_o, dec_rd_v, dec_rd_o;
  hist_req_t          s2;

  logic                fwd_inc_vld, fwd_dec_vld;
  logic [SAMPLE_W-1:0] fwd_inc_addr, fwd_dec_addr;
  logic [COUNT_W-1:0]  fwd_inc_data, fwd_dec_data;

  logic [COUNT_W-1:0] distinct_total;
  logic [COUNT_W-1:0] distinct_total_next;

  logic [COUNT_W-1:0] iv, io, dv, dco;
  logic [COUNT_W-1:0] cnt_old, cnt_v, old_after, cur_v, tot_base, tot_mid;
  logic               dec_we;
  logic [COUNT_W-1:0] inc_wdata, dec_wdata;

  // Advance the item into the update stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
    end else begin
      s2 <= req;
    end
  end

  // Read both addresses of both memories, write back the update
  always_ff @(posedge clk) begin
    inc_rd_v <= inc_mem[req.sample];
    inc_rd_o <= inc_mem[req.old];
    dec_rd_v <= dec_mem[req.sample];
    dec_rd_o <= dec_mem[req.old];
    if (s2.vld) begin
      inc_mem[s2.sample] <= inc_wdata;
    end
    if (dec_we) begin
      dec_mem[s2.old] <= dec_wdata;
    end
  end

  // Pick the freshest copy of each count: forwarded, stored, or cleared
  always_comb begin
    if (s2.start) begin
      iv  = '0;
      io  = '0;
      dv  = '0;
      dco = '0;
    end else begin
      if (fwd_inc_vld && fwd_inc_addr == s2.sample) iv = fwd_inc_data;
      else if (inc_valid[s2.sample])                iv = inc_rd_v;
      else                                          iv = '0;
      if (fwd_inc_vld && fwd_inc_addr == s2.old)    io = fwd_inc_data;
      else if (inc_valid[s2.old])                   io = inc_rd_o;
      else                                          io = '0;
      if (fwd_dec_vld && fwd_dec_addr == s2.sample) dv = fwd_dec_data;
      else if (dec_valid[s2.sample])                dv = dec_rd_v;
      else                                          dv = '0;
      if (fwd_dec_vld && fwd_dec_addr == s2.old)    dco = fwd_dec_data;
      else if (dec_valid[s2.old])                   dco = dec_rd_o;
      else                                          dco = '0;
    end
  end

  // Drop the leaving value, add the entering one, track the nonzero total
  always_comb begin
    cnt_old   = io - dco;
    cnt_v     = iv - dv;
    dec_we    = s2.vld && s2.evict && (cnt_old != '0);
    old_after = cnt_old - COUNT_W'(1);
    tot_base  = s2.start ? '0 : distinct_total;
    if (dec_we && old_after == '0 && tot_base != '0) begin
      tot_mid = tot_base - COUNT_W'(1);
    end else begin
      tot_mid = tot_base;
    end
    if (s2.evict && s2.old == s2.sample) begin
      cur_v = dec_we ? old_after : cnt_old;
    end else begin
      cur_v = cnt_v;
    end
    distinct_total_next = (cur_v == '0) ? tot_mid + COUNT_W'(1) : tot_mid;
    inc_wdata = iv + COUNT_W'(1);
    dec_wdata = dco + COUNT_W'(1);
  end

  // Hold the total, valid bits and forwarding copies
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      distinct_total <= '0;
      inc_valid      <= '0;
      dec_valid      <= '0;
      fwd_inc_vld    <= 1'b0;
      fwd_dec_vld    <= 1'b0;
    end else begin
      fwd_inc_vld <= s2.vld;
      fwd_dec_vld <= dec_we;
      if (s2.vld) begin
        distinct_total <= distinct_total_next;
        if (s2.start) begin
          inc_valid <= VALUE_COUNT'(1) << s2.sample;
          dec_valid <= '0;
        end else begin
          inc_valid[s2.sample] <= 1'b1;
          if (dec_we) begin
            dec_valid[s2.old] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_inc_addr <= s2.sample;
    fwd_inc_data <= inc_wdata;
    fwd_dec_addr <= s2.old;
    fwd_dec_data <= dec_wdata;
  end

  assign rsp.vld      = s2.vld && s2.emit;
  assign rsp.distinct = distinct_total_next;

endmodule

[sv/sliding_window_distinct_count.sv]
// ----------------------------------------------------------------------------
// sliding_window_distinct_count
// Counts distinct values over a sliding window of recent samples.
// ----------------------------------------------------------------------------
// The block takes one sample per clock and, once the window holds
// window_size samples, presents the number of distinct values in it on the
// result channel through the output queue. The rate of one item per cycle
// is set by the histogram read-modify-write: counts are read from two
// one-port-write memories in the stage ahead of the update and the previous
// item's writes are forwarded. The ring of recent samples is a memory read and
// written at the same slot in the accepting cycle. A four-entry output queue
// decouples the result side; the sample side stalls only when the queue could
// not absorb every item still in the two pipeline stages. Start flags and
// window_size writes clear the histogram at once through valid bits, so there
// is no clearing pass after reset. Write window_size only when the block is
// idle; a write restarts the stream.
// ----------------------------------------------------------------------------
module sliding_window_distinct_count (
  input  logic                                clk,
  input  logic                                rst,
  swdc_in_if.sink                             sample_ch,
  swdc_out_if.source                          result_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swdc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [swdc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [swdc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import swdc_pkg::*;

  logic [WSIZE_W-1:0]  window_size;
  logic [FILL_W-1:0]   win_eff;
  logic                cfg_wr;

  logic [PTR_W-1:0]    ring_ptr;
  logic [FILL_W-1:0]   fill_level;
  logic [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
  logic [SAMPLE_W-1:0] ring_rd;

  logic                accept;
  logic [PTR_W-1:0]    slot;
  logic [FILL_W-1:0]   fill_base, fill_level_next, slot_inc;
  logic [PTR_W-1:0]    ring_ptr_next;
  logic                evict, emit;

  logic                s1_vld, s1_start, s1_evict, s1_emit;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s2_busy;

  hist_req_t           hreq;
  hist_rsp_t           hrsp;

  logic [COUNT_W-1:0]    fifo_mem [FIFO_DEPTH];
  logic [FIFO_IDX_W-1:0] fifo_wr, fifo_rd;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic                  fifo_pop;
  logic [FIFO_CNT_W:0]   in_flight;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);
  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ?
                  APB_DATA_W'(window_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_W'(1);
    end else if (cfg_wr) begin
      window_size <= pwdata[WSIZE_W-1:0];
    end
  end

  // Clamp the window length into 1..WINDOW_MAX
  always_comb begin
    if (window_size == '0) begin
      win_eff = FILL_W'(1);
    end else if (FILL_W'(window_size) > FILL_W'(WINDOW_MAX)) begin
      win_eff = FILL_W'(WINDOW_MAX);
    end else begin
      win_eff = FILL_W'(window_size);
    end
  end

  // Accept when the queue can absorb everything in flight
  assign in_flight       = (FIFO_CNT_W + 1)'(fifo_count) + (FIFO_CNT_W + 1)'(s1_vld)
                         + (FIFO_CNT_W + 1)'(s2_busy);
  assign sample_ch.ready = in_flight < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign accept          = sample_ch.valid && sample_ch.ready;

  // Slot, eviction and fill for the entering sample
  always_comb begin
    fill_base       = sample_ch.start_req ? '0 : fill_level;
    slot            = sample_ch.start_req ? '0 : ring_ptr;
    evict           = fill_base >= win_eff;
    fill_level_next = evict ? fill_base : fill_base + FILL_W'(1);
    emit            = fill_level_next >= win_eff;
    slot_inc        = FILL_W'(slot) + FILL_W'(1);
    ring_ptr_next   = (slot_inc == win_eff) ? '0 : slot_inc[PTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      ring_ptr   <= '0;
      fill_level <= '0;
    end else if (accept) begin
      ring_ptr   <= ring_ptr_next;
      fill_level <= fill_level_next;
    end
  end

  // Ring memory: read the leaving sample, write the entering one
  always_ff @(posedge clk) begin
    ring_rd <= ring_mem[slot];
    if (accept) begin
      ring_mem[slot] <= sample_ch.sample;
    end
  end

  // Hold the item while its histogram reads are issued
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_busy <= 1'b0;
    end else begin
      s1_vld  <= accept;
      s2_busy <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_start  <= sample_ch.start_req;
    s1_evict  <= evict;
    s1_emit   <= emit;
    s1_sample <= sample_ch.sample;
  end

  always_comb begin
    hreq.vld    = s1_vld;
    hreq.start  = s1_start;
    hreq.evict  = s1_evict;
    hreq.emit   = s1_emit;
    hreq.sample = s1_sample;
    hreq.old    = ring_rd;
  end

  swdc_hist u_hist (
    .clk   (clk),
    .rst   (rst),
    .clear (cfg_wr),
    .req   (hreq),
    .rsp   (hrsp)
  );

  // Output queue
  assign fifo_pop           = result_ch.valid && result_ch.ready;
  assign result_ch.valid    = fifo_count != '0;
  assign result_ch.distinct = fifo_mem[fifo_rd];

  always_ff @(posedge clk) begin
    if (hrsp.vld) begin
      fifo_mem[fifo_wr] <= hrsp.distinct;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wr    <= '0;
      fifo_rd    <= '0;
      fifo_count <= '0;
    end else begin
      if (hrsp.vld) begin
        fifo_wr <= fifo_wr + FIFO_IDX_W'(1);
      end
      if (fifo_pop) begin
        fifo_rd <= fifo_rd + FIFO_IDX_W'(1);
      end
      fifo_count <= fifo_count + FIFO_CNT_W'(hrsp.vld) - FIFO_CNT_W'(fifo_pop);
    end
  end

  // Checks
  a_fifo_no_overflow: assert property (@(posedge clk) disable iff (rst)
    hrsp.vld |-> (fifo_count < FIFO_CNT_W'(FIFO_DEPTH)) || fifo_pop)
    else $error("result queue overflow");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_level <= win_eff)
    else $error("fill level beyond window");

  a_ptr_bounded: assert property (@(posedge clk) disable iff (rst)
    FILL_W'(ring_ptr) < win_eff)
    else $error("ring pointer beyond window");

  a_emit_after_full: assert property (@(posedge clk) disable iff (rst)
    accept && !sample_ch.start_req && (fill_level >= win_eff) |=> s1_emit)
    else $error("full window item gave no result");

endmodule

[verif/swdc_result_checker.sv]
// ----------------------------------------------------------------------------
// swdc_result_checker
// Watches the sample, result and APB ports of the distinct counter, keeps its
// own histogram and window ring, and compares each result transaction with
// the oldest predicted count.
// ----------------------------------------------------------------------------
module swdc_result_checker
  import swdc_pkg::*;
#(
  parameter logic [APB_ADDR_W-1:0] WSIZE_ADDR = '0
) (
  input  logic                  clk,
  input  logic                  rst,
  swdc_in_if                    sample_mon,
  swdc_out_if                   result_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending
);

  // Predicted block state
  int unsigned         occur [VALUE_COUNT];
  logic [SAMPLE_W-1:0] recent [WINDOW_MAX];
  int unsigned         slot;
  int unsigned         held;
  int unsigned         distinct_now;
  logic [WSIZE_W-1:0]  wsize;

  // Distinct counts still owed by the block, oldest first
  logic [COUNT_W-1:0]  distinct_q [$];

  int fail_total = 0;
  int waiting    = 0;

  assign fail_count = fail_total;
  assign pending    = waiting;

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_total++;
  endtask

  // Drop the histogram, the fill and the count; the ring keeps its contents
  function automatic void restart_window();
    foreach (occur[i]) occur[i] = 0;
    slot         = 0;
    held         = 0;
    distinct_now = 0;
  endfunction

  // Take one sample into the window and queue the count it produces
  function automatic void advance_window(input logic [SAMPLE_W-1:0] v, input logic st);
    int unsigned         span;
    int unsigned         pos;
    logic [SAMPLE_W-1:0] leaving;
    // Zero acts as one, anything past the ring acts as the ring size
    span = (wsize == 0) ? 1 : ((wsize > WINDOW_MAX) ? WINDOW_MAX : wsize);
    if (st) begin
      restart_window();
    end
    pos = slot % span;
    // Evict the oldest sample once the window is full
    if (held >= span) begin
      leaving = recent[pos];
      if (occur[leaving] != 0) begin
        occur[leaving]--;
        if (occur[leaving] == 0 && distinct_now != 0) begin
          distinct_now--;
        end
      end
    end
    if (occur[v] == 0) begin
      distinct_now++;
    end
    occur[v]++;
    recent[pos] = v;
    slot = (pos + 1) % span;
    if (held < span) begin
      held++;
    end
    if (held >= span) begin
      distinct_q.push_back(COUNT_W'(distinct_now));
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      wsize = WSIZE_W'(1);
      restart_window();
      distinct_q.delete();
    end else begin
      // A window_size write restarts the stream
      if (psel && penable && pwrite && pready && paddr == WSIZE_ADDR) begin
        wsize = pwdata[WSIZE_W-1:0];
        restart_window();
      end
      // Compare the result transaction with the oldest prediction
      if (result_mon.valid && result_mon.ready) begin
        if (distinct_q.size() == 0) begin
          report($sformatf("unexpected result, distinct=%0d", result_mon.distinct));
        end else begin
          if (result_mon.distinct !== distinct_q[0]) begin
            report($sformatf("distinct got %0d, expected %0d",
                             result_mon.distinct, distinct_q[0]));
          end
          void'(distinct_q.pop_front());
        end
      end
      // Predict from the accepted sample transaction
      if (sample_mon.valid && sample_mon.ready) begin
        advance_window(sample_mon.sample, sample_mon.start_req);
      end
    end
    waiting = distinct_q.size();
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench top for the sliding-window distinct counter.
// Drives a short directed sequence and then phases of random sample arrays
// under several window sizes, with random idle bursts on both channels. The
// checker beside the block predicts every count and reports mismatches.
// ----------------------------------------------------------------------------
module tb;
  import swdc_pkg::*;

  localparam logic [APB_ADDR_W-1:0] WSIZE_ADDR = APB_ADDR_W'(4 * REG_WINDOW_SIZE);
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASES        = 12;
  localparam int FIXED_SIZES [9] = '{128, 2, 255, 1, 0, 5, 64, 127, 3};

  typedef enum int {FILL_RAMP, FILL_RANDOM, FILL_NARROW} fill_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int stall_odds  = 4;
  bit valid_up    = 0;

  swdc_in_if  sample_ch ();
  swdc_out_if result_ch ();

  sliding_window_distinct_count dut (
    .clk       (clk),
    .rst       (rst),
    .sample_ch (sample_ch),
    .result_ch (result_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  swdc_result_checker #(.WSIZE_ADDR(WSIZE_ADDR)) count_check (
    .clk        (clk),
    .rst        (rst),
    .sample_mon (sample_ch),
    .result_mon (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d counts outstanding", cycle_count, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: hold ready low in random bursts
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
    end
  end

  // Offer one sample transaction, then maybe idle for a burst
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic st);
    sample_ch.valid     <= 1'b1;
    sample_ch.sample    <= s;
    sample_ch.start_req <= st;
    valid_up = 1;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      sample_ch.valid <= 1'b0;
      valid_up = 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Hold the sender until every predicted count has come back
  task automatic wait_results();
    if (valid_up) begin
      sample_ch.valid <= 1'b0;
      valid_up = 0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Let the block go idle, then write window_size over APB
  task automatic write_window(input logic [WSIZE_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    word = $urandom();
    word[WSIZE_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WSIZE_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int                  span;
    int                  budget;
    int                  sent;
    int                  len;
    int                  top;
    int                  base;
    logic [SAMPLE_W-1:0] s;
    logic                st;
    logic [WSIZE_W-1:0]  wsize;
    fill_mode_t          mode;

    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    sample_ch.valid     <= 1'b0;
    sample_ch.sample    <= '0;
    sample_ch.start_req <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Window of one after reset: every sample counts alone
    send_sample(7'd0, 1'b0);
    send_sample(7'd127, 1'b0);
    send_sample(7'd5, 1'b1);

    // Window size zero behaves as one
    write_window(8'd0);
    send_sample(7'd127, 1'b0);
    send_sample(7'd0, 1'b1);

    // Window of three: fill, repeats, eviction, restart mid-stream
    write_window(8'd3);
    send_sample(7'd7, 1'b0);
    send_sample(7'd7, 1'b0);
    send_sample(7'd7, 1'b0);
    send_sample(7'd8, 1'b0);
    send_sample(7'd9, 1'b0);
    send_sample(7'd7, 1'b0);
    send_sample(7'd9, 1'b0);
    send_sample(7'd127, 1'b1);
    send_sample(7'd0, 1'b0);
    send_sample(7'd127, 1'b0);
    send_sample(7'd0, 1'b0);

    // Window of two: count drops back to one on a repeated value
    write_window(8'd2);
    send_sample(7'd1, 1'b0);
    send_sample(7'd2, 1'b0);
    send_sample(7'd1, 1'b0);
    send_sample(7'd1, 1'b0);
    send_sample(7'd126, 1'b1);
    send_sample(7'd3, 1'b0);

    // Random phases, one window size each
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < $size(FIXED_SIZES)) begin
        wsize = WSIZE_W'(FIXED_SIZES[phase]);
      end else begin
        wsize = WSIZE_W'($urandom_range(1, WINDOW_MAX));
      end
      // No idling in the closing phases
      if (phase >= PHASES - 2) begin
        stall_odds = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            stall_odds = 0;
          end
          1: begin
            stall_odds = 3;
          end
          default: begin
            stall_odds = 8;
          end
        endcase
      end
      write_window(wsize);
      span   = (wsize == 0) ? 1 : ((wsize > WINDOW_MAX) ? WINDOW_MAX : wsize);
      budget = 50 + span;
      sent   = 0;
      while (sent < budget) begin
        // Mostly arrays that fill the window; some stop short of it
        if ($urandom_range(0, 4) != 0) begin
          len = span + $urandom_range(0, 40);
        end else begin
          len = $urandom_range(1, span);
        end
        // Stay within the phase budget
        if (len > budget - sent) begin
          len = budget - sent;
        end
        // Open each phase with a ramp so the count can reach the window size
        if (sent == 0) begin
          mode = FILL_RAMP;
        end else begin
          mode = fill_mode_t'($urandom_range(0, 2));
        end
        base = $urandom_range(0, VALUE_COUNT - 1);
        top  = (1 << $urandom_range(0, 4)) - 1;
        for (int k = 0; k < len; k++) begin
          case (mode)
            FILL_RAMP: begin
              s = SAMPLE_W'(base + k);
            end
            FILL_RANDOM: begin
              s = SAMPLE_W'($urandom_range(0, VALUE_COUNT - 1));
            end
            default: begin
              s = SAMPLE_W'(base + $urandom_range(0, top));
            end
          endcase
          if (k == 0) begin
            st = ($urandom_range(0, 9) != 0);
          end else begin
            st = ($urandom_range(0, 59) == 0);
          end
          send_sample(s, st);
        end
        // Pause the sender until the result side has caught up
        if ((phase == 1 && sent == 0) || $urandom_range(0, 9) == 0) begin
          wait_results();
        end
        sent += len;
      end
    end

    // Drain and give the verdict
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/swdc_pkg.sv
sv/swdc_in_if.sv
sv/swdc_out_if.sv
sv/swdc_hist.sv
sv/sliding_window_distinct_count.sv
verif/swdc_result_checker.sv
verif/tb.sv
